>>> hw/rtl/rme_pkg.sv
// Shared widths, constants and the arctangent table of the rotation-to-Euler core.
`timescale 1ns / 1ps
`default_nettype none
package rme_pkg;
    localparam int IN_W         = 18;
    localparam int OP_W         = IN_W + 1;
    localparam int ANG_W        = 16;
    localparam int THR_W        = 17;
    localparam int SQ_W         = 2 * IN_W;
    localparam int ROOT_W       = IN_W;
    localparam int REM_W        = SQ_W + 1;
    localparam int PRESCALE     = 40;
    localparam int CW           = OP_W + PRESCALE + 3;
    localparam int ZW           = 34;
    localparam int CORDIC_STEPS = 32;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
    localparam int SQRT_LAT     = ROOT_W;
    localparam int IN_FRAC_BITS    = 16;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int RND_SHIFT    = 30 - ANGLE_FRAC_BITS;
    localparam int QW           = ZW - RND_SHIFT;

    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sh6487ED51;
    localparam logic signed [ZW-1:0] PI_Q30      = 34'shC90FDAA2;
    localparam logic signed [QW-1:0] ANG_LIM     =
        QW'((PI_Q30 + (ZW'(1) <<< (RND_SHIFT - 1))) >>> RND_SHIFT);

    typedef logic signed [IN_W-1:0] elem_t;
    typedef logic signed [OP_W-1:0] op_t;

    function automatic logic [31:0] atan_q30(input int i);
        logic [31:0] r;
        case (i)
            0:  r = 32'h3243F6A8;  1:  r = 32'h1DAC6705;  2:  r = 32'h0FADBAFC;
            3:  r = 32'h07F56EA6;  4:  r = 32'h03FEAB76;  5:  r = 32'h01FFD55B;
            6:  r = 32'h00FFFAAA;  7:  r = 32'h007FFF55;  8:  r = 32'h003FFFEA;
            9:  r = 32'h001FFFFD;  10: r = 32'h000FFFFF;  11: r = 32'h0007FFFF;
            12: r = 32'h0003FFFF;  13: r = 32'h0001FFFF;  14: r = 32'h0000FFFF;
            15: r = 32'h00007FFF;  16: r = 32'h00003FFF;  17: r = 32'h00001FFF;
            18: r = 32'h00000FFF;  19: r = 32'h000007FF;  20: r = 32'h000003FF;
            21: r = 32'h000001FF;  22: r = 32'h000000FF;  23: r = 32'h0000007F;
            24: r = 32'h0000003F;  25: r = 32'h0000001F;  26: r = 32'h0000000F;
            27: r = 32'h00000008;  28: r = 32'h00000004;  29: r = 32'h00000002;
            30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

>>> hw/rtl/rme_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module rme_isqrt (
    input  wire logic                       aclk,
    input  wire logic                       en,
    input  wire logic [rme_pkg::SQ_W-1:0]   radicand,
    output logic      [rme_pkg::ROOT_W-1:0] root
);
    import rme_pkg::*;

    logic [REM_W-1:0]  rem_reg  [1:SQRT_LAT];
    logic [ROOT_W-1:0] root_reg [1:SQRT_LAT];

    for (genvar k = 0; k < SQRT_LAT; k++) begin : g_stage
        localparam int I = ROOT_W - 1 - k;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [REM_W-1:0]  trial;
        if (k == 0) begin : g_first
            assign rem_in  = {1'b0, radicand};
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = rem_reg[k];
            assign root_in = root_reg[k];
        end
        assign trial = ({{(REM_W-ROOT_W-1){1'b0}}, root_in, 1'b0}
                        + (REM_W'(1) << I)) << I;
        always_ff @(posedge aclk) begin
            if (en) begin
                if (rem_in >= trial) begin
                    rem_reg[k+1]  <= rem_in - trial;
                    root_reg[k+1] <= root_in | (ROOT_W'(1) << I);
                end else begin
                    rem_reg[k+1]  <= rem_in;
                    root_reg[k+1] <= root_in;
                end
            end
        end
    end

    assign root = root_reg[SQRT_LAT];
endmodule
`default_nettype wire

>>> hw/rtl/rme_cordic.sv
// Unrolled vectoring CORDIC atan2 with rounding and clamping of the angle.
`timescale 1ns / 1ps
`default_nettype none
module rme_cordic (
    input  wire logic                      aclk,
    input  wire logic                      en,
    input  wire rme_pkg::op_t              a,
    input  wire rme_pkg::op_t              b,
    output logic signed [rme_pkg::ANG_W-1:0] angle
);
    import rme_pkg::*;

    logic signed [CW-1:0] x_reg [0:CORDIC_STEPS];
    logic signed [CW-1:0] y_reg [0:CORDIC_STEPS];
    logic signed [ZW-1:0] z_reg [0:CORDIC_STEPS];
    logic                 zero_reg [0:CORDIC_STEPS];
    logic signed [CW-1:0] xs, ys;
    logic signed [QW-1:0] q;
    logic signed [ZW-1:0] zr;

    assign xs = CW'(b) <<< PRESCALE;
    assign ys = CW'(a) <<< PRESCALE;

    always_ff @(posedge aclk) begin
        if (en) begin
            zero_reg[0] <= (a == '0) && (b == '0);
            if (xs < 0) begin
                if (ys >= 0) begin
                    x_reg[0] <= ys;  y_reg[0] <= -xs; z_reg[0] <= HALF_PI_Q30;
                end else begin
                    x_reg[0] <= -ys; y_reg[0] <= xs;  z_reg[0] <= -HALF_PI_Q30;
                end
            end else begin
                x_reg[0] <= xs; y_reg[0] <= ys; z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic signed [ZW-1:0] ang;
        assign ang = ZW'(atan_q30(i));
        always_ff @(posedge aclk) begin
            if (en) begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ang;
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ang;
                end
            end
        end
    end

    assign zr = z_reg[CORDIC_STEPS] + (ZW'(1) <<< (RND_SHIFT - 1));
    assign q  = QW'(zr >>> RND_SHIFT);

    always_ff @(posedge aclk) begin
        if (en) begin
            if (zero_reg[CORDIC_STEPS]) angle <= '0;
            else if (q > ANG_LIM)       angle <= ANG_W'(ANG_LIM);
            else if (q < -ANG_LIM)      angle <= ANG_W'(-ANG_LIM);
            else                        angle <= ANG_W'(q);
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/rotation_matrix_to_euler_core.sv
// Top level: rotation matrix to x-y-z Euler angles, fully pipelined.
// One matrix request is taken every cycle; the whole pipeline holds while the result
// is not taken. Each result passes a squaring stage, a sum stage, 18 square-root stages
// and 34 CORDIC stages with pre-rotation and rounding. The user must write the singular
// threshold through the cfg port while no request is in flight; it is not enforced.
`timescale 1ns / 1ps
`default_nettype none
module rotation_matrix_to_euler_core (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,   // m00, m10, m11, m12, m20, m21, m22, zero pad
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [47:0]       m_tdata,   // angle_x, angle_y, angle_z
    output logic [0:0]        m_tuser,   // singular
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [16:0]  cfg_data   // singular_threshold
);
    import rme_pkg::*;

    localparam int TOTAL_LAT = 2 + SQRT_LAT + CORDIC_LAT;

    typedef struct packed {
        elem_t m11, m12, m20, m21, m22, m00, m10;
    } side_t;

    logic                  en;
    logic [THR_W-1:0]      thr_reg;
    logic [TOTAL_LAT-1:0]  vld_reg;
    logic [CORDIC_LAT-1:0] sing_reg;
    side_t                 a_side_reg, in_side;
    side_t                 side_reg [0:SQRT_LAT];
    logic [SQ_W-2:0]       sq0_reg, sq1_reg;
    logic [SQ_W-1:0]       sum_reg;
    logic [ROOT_W-1:0]     root;
    logic                  sing;
    side_t                 sd;
    op_t                   ax, bx, ay, by, az, bz;
    logic signed [ANG_W-1:0] ang_x, ang_y, ang_z;

    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = vld_reg[TOTAL_LAT-1];
    assign m_tdata   = {ang_z, ang_y, ang_x};
    assign m_tuser   = sing_reg[CORDIC_LAT-1];

    assign in_side.m00 = s_tdata[17:0];
    assign in_side.m10 = s_tdata[35:18];
    assign in_side.m11 = s_tdata[53:36];
    assign in_side.m12 = s_tdata[71:54];
    assign in_side.m20 = s_tdata[89:72];
    assign in_side.m21 = s_tdata[107:90];
    assign in_side.m22 = s_tdata[125:108];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg  <= THR_W'(1);
            vld_reg  <= '0;
        end else begin
            if (cfg_valid) thr_reg <= cfg_data;
            if (en) vld_reg <= {vld_reg[TOTAL_LAT-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_side_reg  <= in_side;
            sq0_reg     <= (SQ_W-1)'(in_side.m00 * in_side.m00);
            sq1_reg     <= (SQ_W-1)'(in_side.m10 * in_side.m10);
            side_reg[0] <= a_side_reg;
            sum_reg     <= {1'b0, sq0_reg} + {1'b0, sq1_reg};
            sing_reg    <= {sing_reg[CORDIC_LAT-2:0], sing};
        end
    end

    for (genvar k = 0; k < SQRT_LAT; k++) begin : g_side
        always_ff @(posedge aclk) begin
            if (en) side_reg[k+1] <= side_reg[k];
        end
    end

    rme_isqrt u_isqrt (
        .aclk     (aclk),
        .en       (en),
        .radicand (sum_reg),
        .root     (root)
    );

    assign sd   = side_reg[SQRT_LAT];
    assign sing = {1'b0, root} < {{(ROOT_W+1-THR_W){1'b0}}, thr_reg};

    assign ay = -OP_W'(sd.m20);
    assign by = OP_W'({1'b0, root});
    assign ax = sing ? -OP_W'(sd.m12) : OP_W'(sd.m21);
    assign bx = sing ?  OP_W'(sd.m11) : OP_W'(sd.m22);
    assign az = sing ? '0 : OP_W'(sd.m10);
    assign bz = sing ? '0 : OP_W'(sd.m00);

    rme_cordic u_cordic_x (.aclk(aclk), .en(en), .a(ax), .b(bx), .angle(ang_x));
    rme_cordic u_cordic_y (.aclk(aclk), .en(en), .a(ay), .b(by), .angle(ang_y));
    rme_cordic u_cordic_z (.aclk(aclk), .en(en), .a(az), .b(bz), .angle(ang_z));
endmodule
`default_nettype wire

>>> tb/tb_rotation_matrix_to_euler_core.sv
// Testbench for the rotation-matrix-to-Euler core: directed table, random matrices, predictor.
`timescale 1ns / 1ps
module tb_rotation_matrix_to_euler_core;
    import rme_pkg::*;

    typedef struct {
        logic signed [17:0] m00, m10, m11, m12, m20, m21, m22;
    } matrix_t;

    typedef struct {
        logic [15:0] ax, ay, az;
        logic        sing;
    } angles_t;

    typedef struct {
        matrix_t m;
        bit      typed;
        angles_t want;
    } row_t;

    localparam longint HALF_PI = 64'sh6487ED51;
    localparam longint PI      = 64'shC90FDAA2;
    localparam int     LIMIT   = 600000;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [47:0]  m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic [16:0]  cfg_data = '0;

    longint  atan_tab [32];
    angles_t pending_angles [$];
    logic [16:0] threshold = 17'd1;
    int      errors = 0;
    int      cycles = 0;
    int      send_idle = 0;
    int      recv_stall = 0;

    rotation_matrix_to_euler_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        atan_tab = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
                     64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
                     64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
                     64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
                     64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
                     64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
                     64'h00000001, 64'h00000000};
    end

    function automatic longint floor_sqrt(longint v);
        longint r;
        r = 0;
        for (int b = 20; b >= 0; b--) begin
            if ((r + (64'sd1 <<< b)) * (r + (64'sd1 <<< b)) <= v)
                r = r + (64'sd1 <<< b);
        end
        return r;
    endfunction

    function automatic logic [15:0] cordic_atan2(longint a, longint b);
        longint x, y, z, t, dx, dy, lim;
        if (a == 0 && b == 0)
            return 16'd0;
        x = b <<< 40;
        y = a <<< 40;
        z = 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = HALF_PI;
            end else begin
                t = x; x = -y; y = t; z = -HALF_PI;
            end
        end
        for (int i = 0; i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += atan_tab[i];
            end else begin
                x -= dx; y += dy; z -= atan_tab[i];
            end
        end
        z = (z + (64'sd1 <<< 16)) >>> 17;
        lim = (PI + (64'sd1 <<< 16)) >>> 17;
        if (z > lim) z = lim;
        if (z < -lim) z = -lim;
        return z[15:0];
    endfunction

    function automatic angles_t euler_angles(matrix_t m);
        angles_t r;
        longint sy;
        sy = floor_sqrt(longint'(m.m00) * m.m00 + longint'(m.m10) * m.m10);
        r.sing = (sy < longint'(threshold));
        r.ay = cordic_atan2(-longint'(m.m20), sy);
        if (!r.sing) begin
            r.ax = cordic_atan2(m.m21, m.m22);
            r.az = cordic_atan2(m.m10, m.m00);
        end else begin
            r.ax = cordic_atan2(-longint'(m.m12), m.m11);
            r.az = 16'd0;
        end
        return r;
    endfunction

    function automatic logic signed [17:0] pick_elem(int mode);
        logic signed [17:0] e;
        int k;
        case (mode)
            0: e = 18'($urandom);
            1: e = 18'($urandom_range(131072) - 65536);
            2: e = 18'($urandom_range(2 * int'(threshold) + 8) - int'(threshold) - 4);
            default: begin
                k = $urandom_range(4);
                e = (k == 0) ? 18'sh20000 : (k == 1) ? 18'sd131071 :
                    (k == 2) ? 18'sd0 : (k == 3) ? 18'sd1 : -18'sd1;
            end
        endcase
        return e;
    endfunction

    function automatic matrix_t random_matrix();
        matrix_t m;
        int mode, sel;
        sel = $urandom_range(9);
        mode = (sel < 3) ? 0 : (sel < 7) ? 1 : (sel < 9) ? 2 : 3;
        m.m00 = pick_elem(mode);
        m.m10 = pick_elem(mode);
        if (mode == 2) mode = 1;
        m.m11 = pick_elem(mode);
        m.m12 = pick_elem(mode);
        m.m20 = pick_elem(mode);
        m.m21 = pick_elem(mode);
        m.m22 = pick_elem(mode);
        return m;
    endfunction

    task automatic report(string what, int got, int want);
        $display("error at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
        errors++;
    endtask

    task automatic send_matrix(matrix_t m, bit typed, angles_t want);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, m.m22, m.m21, m.m20, m.m12, m.m11, m.m10, m.m00};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_angles.insert(pending_angles.size(), typed ? want : euler_angles(m));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_angles.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_threshold(logic [16:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        threshold = v;
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("rotation_matrix_to_euler_core: mismatch");
            $finish;
        end
        m_tready <= ($urandom_range(99) >= recv_stall);
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_angles.size() == 0) begin
                report("unexpected request", 0, 0);
            end else begin
                angles_t w;
                w = pending_angles.pop_front();
                if (m_tdata[15:0] !== w.ax)
                    report("angle_x", $signed(m_tdata[15:0]), $signed(w.ax));
                if (m_tdata[31:16] !== w.ay)
                    report("angle_y", $signed(m_tdata[31:16]), $signed(w.ay));
                if (m_tdata[47:32] !== w.az)
                    report("angle_z", $signed(m_tdata[47:32]), $signed(w.az));
                if (m_tuser[0] !== w.sing)
                    report("singular", m_tuser[0], w.sing);
            end
        end
    end

    initial begin
        row_t    dir [$];
        row_t    r;
        angles_t none;
        int      idle_tab [5];
        int      stall_tab [5];
        logic [16:0] thr_tab [5];

        none = '{16'd0, 16'd0, 16'd0, 1'b1};
        idle_tab  = '{0, 88, 0, 32, 0};
        stall_tab = '{0, 0, 88, 32, 0};
        thr_tab   = '{17'd65536, 17'd0, 17'd131071, 17'd1, 17'd40000};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero matrix: sy is zero, every angle zero, singular
        dir.insert(dir.size(), '{'{0, 0, 0, 0, 0, 0, 0}, 1'b1, none});
        dir.insert(dir.size(), '{'{65536, 0, 65536, 0, 0, 0, 65536}, 1'b0, none});
        dir.insert(dir.size(),
                   '{'{131071, 131071, 131071, 131071, 131071, 131071, 131071}, 1'b0, none});
        dir.insert(dir.size(),
                   '{'{-131072, -131072, -131072, -131072, -131072, -131072, -131072},
                     1'b0, none});
        dir.insert(dir.size(), '{'{-65536, 0, 0, 0, 0, 65536, -65536}, 1'b0, none});
        dir.insert(dir.size(), '{'{-65536, -1, 0, 0, 0, -65536, -65536}, 1'b0, none});
        dir.insert(dir.size(), '{'{-1, 1, 0, 0, 131071, 1, -1}, 1'b0, none});
        dir.insert(dir.size(), '{'{0, 0, -65536, 65536, -65536, 0, 0}, 1'b0, none});
        dir.insert(dir.size(), '{'{0, 0, 65536, -65536, 65536, 0, 0}, 1'b0, none});
        dir.insert(dir.size(), '{'{1, 0, -131072, 131071, -131072, 0, 0}, 1'b0, none});
        dir.insert(dir.size(), '{'{0, -1, 0, 0, 0, 0, 0}, 1'b0, none});
        dir.insert(dir.size(),
                   '{'{46341, -46341, 46341, 46341, 0, -46341, 46341}, 1'b0, none});
        foreach (dir[i]) begin
            r = dir[i];
            send_matrix(r.m, r.typed, r.want);
        end

        for (int p = 0; p < 5; p++) begin
            write_threshold(thr_tab[p]);
            send_idle = idle_tab[p];
            recv_stall = stall_tab[p];
            if (p == 4) begin
                write_threshold(17'd65535);
                for (int i = 0; i < 12; i++) begin
                    matrix_t m;
                    m = random_matrix();
                    m.m00 = 18'($urandom_range(65535));
                    m.m10 = 0;
                    send_matrix(m, 1'b0, none);
                end
            end
            for (int i = 0; i < 78; i++) begin
                if (p == 1 && i == 40)
                    drain();
                send_matrix(random_matrix(), 1'b0, none);
            end
        end

        s_tvalid <= 1'b0;
        while (pending_angles.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
        if (errors == 0)
            $display("rotation_matrix_to_euler_core: match");
        else
            $display("rotation_matrix_to_euler_core: mismatch");
        $finish;
    end
endmodule
